/* rtl/binary_min_heap_queue_core_defines.svh */
// Assertion macros shared by the heap queue RTL.
// Each macro expands to one labelled concurrent assertion that is switched
// off while reset is held.
`ifndef BINARY_MIN_HEAP_QUEUE_CORE_DEFINES_SVH
`define BINARY_MIN_HEAP_QUEUE_CORE_DEFINES_SVH

// Condition that must hold in the same cycle as the trigger.
`define BMHQ_ASSERT_NOW(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error(msg);

// Condition that must hold in the cycle after the trigger.
`define BMHQ_ASSERT_NEXT(label, clk, rst, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error(msg);

`endif

/* rtl/bmhq_pkg.sv */
`timescale 1ns / 1ps

package bmhq_pkg;

  localparam int KEY_W     = 32;
  localparam int FIELD_W   = 16;
  localparam int COUNT_W   = 9;
  localparam int STATUS_W  = 2;

  localparam logic ACT_PUSH = 1'b0;
  localparam logic ACT_POP  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic               action;
    logic [KEY_W-1:0]   prio;
    logic [FIELD_W-1:0] task_release;
    logic [FIELD_W-1:0] task_proc;
    logic [FIELD_W-1:0] task_delivery;
    logic [FIELD_W-1:0] task_id;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;
    logic                is_empty;
    logic [KEY_W-1:0]    front_prio;
    logic [FIELD_W-1:0]  front_release;
    logic [FIELD_W-1:0]  front_proc;
    logic [FIELD_W-1:0]  front_delivery;
    logic [FIELD_W-1:0]  front_id;
  } res_t;

  // One heap entry as it is held in the store.
  typedef struct packed {
    logic [KEY_W-1:0]   key;
    logic [FIELD_W-1:0] release_t;
    logic [FIELD_W-1:0] proc_t;
    logic [FIELD_W-1:0] delivery_t;
    logic [FIELD_W-1:0] id;
  } entry_t;

endpackage

/* rtl/binary_min_heap_queue_core.sv */
`timescale 1ns / 1ps
// Binary min-heap priority queue of task entries keyed by a 32-bit priority.
// Commands arrive on the cmd channel (valid/ready): a push inserts the entry,
// a pop removes the root. Every command gives exactly one result item on the
// res channel (valid/ready) with the status, the entry count and the root
// entry after the operation; an empty heap reports a root of all ones.
// Popping an empty heap or pushing onto a full one leaves the heap unchanged.
// The block works on one command at a time. A taken push runs S_UP, one
// parent key compared per step (skipped on an empty heap), then S_FIN and
// S_RES; a pop that leaves entries behind runs S_LOAD, S_DOWN with one
// child pair compared per step (skipped if one entry is left), then S_FIN
// and S_RES. A refused command or the pop of the last entry goes straight
// to S_RES, and the next command is accepted once the result is loaded.
// The entry store has a registered read, so each level of the sift needs
// one read result before the next compare.
// Reset clears the entry count and the result valid flag; the store itself
// is not cleared, since only entries within the count are ever used.
// When the receiver stalls, the finished result waits in the output register
// and the next result is held back until it has been taken.

`include "binary_min_heap_queue_core_defines.svh"

module binary_min_heap_queue_core #(
  parameter int CAPACITY = 256
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  bmhq_pkg::cmd_t  cmd,
  output logic            res_valid,
  input  logic            res_ready,
  output bmhq_pkg::res_t  res
);

  // Count runs 0..CAPACITY; store addresses run 0..CAPACITY-1 and hold heap
  // positions 1..CAPACITY. Wide indices leave room for child positions.
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int AW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IW  = CW + 2;
  localparam int EcW = bmhq_pkg::COUNT_W;

  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a command
  localparam logic [2:0] S_UP   = 3'd1;  // sift-up compare with the parent
  localparam logic [2:0] S_LOAD = 3'd2;  // last entry arrives for a pop
  localparam logic [2:0] S_DOWN = 3'd3;  // sift-down compare with children
  localparam logic [2:0] S_FIN  = 3'd4;  // place the moving entry
  localparam logic [2:0] S_RES  = 3'd5;  // hand the result to the output

  logic [2:0]                   state;
  logic [CW-1:0]                count;
  logic [CW-1:0]                pos;
  bmhq_pkg::entry_t             held;
  bmhq_pkg::entry_t             root;
  logic [bmhq_pkg::STATUS_W-1:0] status;

  // Entry store: one write port, two registered read ports.
  bmhq_pkg::entry_t mem [CAPACITY];
  bmhq_pkg::entry_t rd0;
  bmhq_pkg::entry_t rd1;
  logic             we;
  logic [AW-1:0]    wa;
  bmhq_pkg::entry_t wd;
  logic [AW-1:0]    ra0;
  logic [AW-1:0]    ra1;

  logic [IW-1:0]    count_w;
  logic [IW-1:0]    pos_w;
  logic [IW-1:0]    child_idx;
  logic [IW-1:0]    pick_idx;
  logic [IW-1:0]    grand_idx;
  logic             right_ok;
  logic             pick_right;
  bmhq_pkg::entry_t cand;
  logic             can_load;
  bmhq_pkg::entry_t cmd_entry;

  function automatic logic [AW-1:0] idx2addr(input logic [IW-1:0] idx);
    logic [IW-1:0] d;
    d = idx - 1'b1;
    return d[AW-1:0];
  endfunction

  assign cmd_ready = (state == S_IDLE);
  assign can_load  = !res_valid || res_ready;

  assign count_w    = IW'(count);
  assign pos_w      = IW'(pos);
  assign child_idx  = pos_w << 1;
  assign right_ok   = (child_idx + 1'b1) <= count_w;
  assign pick_right = right_ok && (rd0.key > rd1.key);
  assign cand       = pick_right ? rd1 : rd0;
  assign pick_idx   = child_idx | IW'(pick_right);
  assign grand_idx  = pick_idx << 1;

  assign cmd_entry.key        = cmd.prio;
  assign cmd_entry.release_t  = cmd.task_release;
  assign cmd_entry.proc_t     = cmd.task_proc;
  assign cmd_entry.delivery_t = cmd.task_delivery;
  assign cmd_entry.id         = cmd.task_id;

  // Store access for the current step.
  always_comb begin
    we  = 1'b0;
    wa  = idx2addr(pos_w);
    wd  = held;
    ra0 = '0;
    ra1 = '0;
    case (state)
      S_IDLE: begin
        // A pop fetches the last entry; a push fetches the new slot's parent.
        if (cmd.action == bmhq_pkg::ACT_POP) begin
          ra0 = idx2addr(count_w);
        end else begin
          ra0 = idx2addr((count_w + 1'b1) >> 1);
        end
      end
      S_UP: begin
        if (rd0.key > held.key) begin
          we  = 1'b1;
          wd  = rd0;
          ra0 = idx2addr(pos_w >> 2);
        end
      end
      S_LOAD: begin
        ra0 = idx2addr(IW'(2));
        ra1 = idx2addr(IW'(3));
      end
      S_DOWN: begin
        if (held.key > cand.key) begin
          we  = 1'b1;
          wd  = cand;
          ra0 = idx2addr(grand_idx);
          ra1 = idx2addr(grand_idx + 1'b1);
        end
      end
      S_FIN: begin
        we = 1'b1;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd0 <= mem[ra0];
    rd1 <= mem[ra1];
  end

  // Payload registers: the moving entry and a copy of the root.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        held <= cmd_entry;
      end
      S_LOAD: begin
        held <= rd0;
      end
      S_DOWN: begin
        if (held.key > cand.key && pos == CW'(1)) begin
          root <= cand;
        end
      end
      S_FIN: begin
        if (pos == CW'(1)) begin
          root <= held;
        end
      end
      default: begin
        held <= held;
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pos       <= '0;
      status    <= bmhq_pkg::ST_DONE;
      res_valid <= 1'b0;
    end else begin
      // The result register is loaded on leaving S_RES and emptied when taken.
      if (state == S_RES && can_load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.action == bmhq_pkg::ACT_PUSH) begin
              if (count_w >= IW'(CAPACITY)) begin
                status <= bmhq_pkg::ST_FULL;
                state  <= S_RES;
              end else begin
                status <= bmhq_pkg::ST_DONE;
                count  <= count + 1'b1;
                pos    <= count + 1'b1;
                state  <= (count == '0) ? S_FIN : S_UP;
              end
            end else begin
              if (count == '0) begin
                status <= bmhq_pkg::ST_EMPTY;
                state  <= S_RES;
              end else if (count == CW'(1)) begin
                status <= bmhq_pkg::ST_DONE;
                count  <= '0;
                state  <= S_RES;
              end else begin
                status <= bmhq_pkg::ST_DONE;
                count  <= count - 1'b1;
                state  <= S_LOAD;
              end
            end
          end
        end
        S_UP: begin
          if (rd0.key > held.key) begin
            pos <= pos >> 1;
            if ((pos >> 1) == CW'(1)) begin
              state <= S_FIN;
            end
          end else begin
            state <= S_FIN;
          end
        end
        S_LOAD: begin
          pos   <= CW'(1);
          state <= (count_w >= IW'(2)) ? S_DOWN : S_FIN;
        end
        S_DOWN: begin
          if (held.key > cand.key) begin
            pos <= pick_idx[CW-1:0];
            if (grand_idx > count_w) begin
              state <= S_FIN;
            end
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          state <= S_RES;
        end
        S_RES: begin
          if (can_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (state == S_RES && can_load) begin
      res.status      <= status;
      res.entry_count <= EcW'(count);
      res.is_empty    <= (count == '0);
      if (count == '0) begin
        res.front_prio     <= '1;
        res.front_release  <= '1;
        res.front_proc     <= '1;
        res.front_delivery <= '1;
        res.front_id       <= '1;
      end else begin
        res.front_prio     <= root.key;
        res.front_release  <= root.release_t;
        res.front_proc     <= root.proc_t;
        res.front_delivery <= root.delivery_t;
        res.front_id       <= root.id;
      end
    end
  end

  // The count never passes the capacity.
  `BMHQ_ASSERT_NOW(a_count_range, clk, rst, 1'b1, count_w <= IW'(CAPACITY), "count over capacity")
  // An accepted command always leaves the idle state.
  `BMHQ_ASSERT_NEXT(a_cmd_starts, clk, rst, cmd_valid && cmd_ready, state != S_IDLE, "command lost")
  // Sift-up only compares below the root.
  `BMHQ_ASSERT_NOW(a_up_below_root, clk, rst, state == S_UP, pos > CW'(1), "sift-up at root")
  // Sift-down only runs where a left child is held.
  `BMHQ_ASSERT_NOW(a_down_child, clk, rst, state == S_DOWN, child_idx <= count_w, "no child")

endmodule

/* dv/binary_min_heap_queue_core_test.sv */
`timescale 1ns / 1ps

module binary_min_heap_queue_core_test;

  // The depth must match the parameter given to the block below, since the
  // full-heap case depends on it.
  localparam int HEAP_DEPTH   = 256;
  localparam int RANDOM_ITEMS = 2000;

  logic clk;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  bmhq_pkg::cmd_t cmd = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  bmhq_pkg::res_t res;

  binary_min_heap_queue_core #(
    .CAPACITY(HEAP_DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .cmd_valid(cmd_valid),
    .cmd_ready(cmd_ready),
    .cmd      (cmd),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Commands waiting to be driven, and the results that the heap model says
  // the block owes us, oldest first.
  bmhq_pkg::cmd_t cmd_pending[$];
  bmhq_pkg::res_t heap_replies_due[$];

  int mismatch_count = 0;

  // Our own copy of the heap. Slots are numbered from one, so the parent of
  // slot p is p/2 and its children are 2p and 2p+1.
  bmhq_pkg::entry_t heap_slot[1:HEAP_DEPTH];
  int     heap_count = 0;

  // Number of entries the heap will hold once every generated command has
  // been applied; the generator uses it to steer towards full and empty.
  int gen_count = 0;
  int item_total = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
  endtask

  task automatic swap_slots(input int a, input int b);
    bmhq_pkg::entry_t held;
    held = heap_slot[a];
    heap_slot[a] = heap_slot[b];
    heap_slot[b] = held;
  endtask

  // Applies one command to the heap copy and returns the result the block
  // should give for it.
  task automatic predict_heap_op(input bmhq_pkg::cmd_t c, output bmhq_pkg::res_t r);
    logic [1:0] outcome;
    int pos;
    int child;
    bit settled;
    outcome = bmhq_pkg::ST_DONE;
    if (c.action == bmhq_pkg::ACT_PUSH) begin
      if (heap_count >= HEAP_DEPTH) begin
        outcome = bmhq_pkg::ST_FULL;
      end else begin
        heap_count++;
        heap_slot[heap_count] = '{key: c.prio, release_t: c.task_release,
                                  proc_t: c.task_proc, delivery_t: c.task_delivery,
                                  id: c.task_id};
        // Climb only while the parent is strictly larger, so equal keys keep
        // their order of arrival along the path.
        pos = heap_count;
        while (pos > 1 && heap_slot[pos / 2].key > heap_slot[pos].key) begin
          swap_slots(pos, pos / 2);
          pos = pos / 2;
        end
      end
    end else begin
      if (heap_count == 0) begin
        outcome = bmhq_pkg::ST_EMPTY;
      end else begin
        swap_slots(1, heap_count);
        heap_count--;
        // Sink the moved entry. The right child wins only when the left one
        // is strictly larger, and a tie with the chosen child stops the walk.
        pos = 1;
        child = 2;
        settled = 1'b0;
        while (!settled && child <= heap_count) begin
          if (child < heap_count && heap_slot[child].key > heap_slot[child + 1].key)
            child++;
          if (heap_slot[pos].key > heap_slot[child].key) begin
            swap_slots(pos, child);
            pos = child;
            child = 2 * pos;
          end else begin
            settled = 1'b1;
          end
        end
      end
    end
    r.status = outcome;
    r.entry_count = heap_count[bmhq_pkg::COUNT_W-1:0];
    r.is_empty = (heap_count == 0);
    if (heap_count == 0) begin
      r.front_prio = '1;
      r.front_release = '1;
      r.front_proc = '1;
      r.front_delivery = '1;
      r.front_id = '1;
    end else begin
      r.front_prio = heap_slot[1].key;
      r.front_release = heap_slot[1].release_t;
      r.front_proc = heap_slot[1].proc_t;
      r.front_delivery = heap_slot[1].delivery_t;
      r.front_id = heap_slot[1].id;
    end
  endtask

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic bmhq_pkg::cmd_t make_push(input logic [31:0] key,
                                               input logic [15:0] rel,
                                               input logic [15:0] proc,
                                               input logic [15:0] dlv,
                                               input logic [15:0] ident);
    bmhq_pkg::cmd_t c;
    c.action = bmhq_pkg::ACT_PUSH;
    c.prio = key;
    c.task_release = rel;
    c.task_proc = proc;
    c.task_delivery = dlv;
    c.task_id = ident;
    return c;
  endfunction

  // Keys are drawn so that ties are common and both ends of the range occur.
  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 7);
    case (r)
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom_range(0, 7);
      4: return $urandom_range(32'hFFFF_FFF0, 32'hFFFF_FFFF);
      default: return $urandom;
    endcase
  endfunction

  function automatic bmhq_pkg::cmd_t random_push();
    return make_push(pick_key(), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
  endfunction

  // The payload of a pop is ignored by the block, but it is still driven
  // with random content.
  function automatic bmhq_pkg::cmd_t random_pop();
    bmhq_pkg::cmd_t c;
    c = make_push($urandom, 16'($urandom), 16'($urandom), 16'($urandom),
                  16'($urandom));
    c.action = bmhq_pkg::ACT_POP;
    return c;
  endfunction

  task automatic queue_cmd(input bmhq_pkg::cmd_t c);
    cmd_pending.push_back(c);
    item_total++;
    if (c.action == bmhq_pkg::ACT_PUSH) begin
      if (gen_count < HEAP_DEPTH) gen_count++;
    end else if (gen_count > 0) begin
      gen_count--;
    end
  endtask

  task automatic fill_to_full();
    int extra;
    extra = $urandom_range(1, 6);
    while (gen_count < HEAP_DEPTH) queue_cmd(random_push());
    repeat (extra) queue_cmd(random_push());
  endtask

  task automatic drain_to_empty();
    int extra;
    extra = $urandom_range(1, 4);
    while (gen_count > 0) queue_cmd(random_pop());
    repeat (extra) queue_cmd(random_pop());
  endtask

  // Stimulus. The whole list of commands is built up front; the driver below
  // hands it to the block at its own pace.
  initial begin
    int kind;
    int seg_len;
    int push_bias;
    int stop_at;

    // Directed items: a pop on an empty heap, both key extremes with all-ones
    // and all-zeros task fields, a run of equal keys to check that ties are
    // broken as the heap walk dictates, then a full drain with one to four pops more.
    queue_cmd(random_pop());
    queue_cmd(make_push(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    queue_cmd(make_push(32'h0, 16'h0, 16'h0, 16'h0, 16'h0));
    queue_cmd(make_push(32'd5, 16'h1111, 16'h2222, 16'h3333, 16'd1));
    queue_cmd(make_push(32'd5, 16'h4444, 16'h5555, 16'h6666, 16'd2));
    queue_cmd(make_push(32'd5, 16'h7777, 16'h8888, 16'h9999, 16'd3));
    queue_cmd(make_push(32'd3, 16'hAAAA, 16'hBBBB, 16'hCCCC, 16'd4));
    queue_cmd(make_push(32'hFFFF_FFFF, 16'hDDDD, 16'hEEEE, 16'h0F0F, 16'd5));
    drain_to_empty();

    // Random part. It opens by filling the heap to the brim so that pushes
    // onto a full heap are met early, then mixes segments that fill, drain,
    // or wander with a random leaning towards push or pop.
    stop_at = item_total + RANDOM_ITEMS;
    fill_to_full();
    while (item_total < stop_at) begin
      kind = $urandom_range(0, 7);
      if (kind == 0) begin
        fill_to_full();
      end else if (kind == 1) begin
        drain_to_empty();
      end else begin
        seg_len = $urandom_range(10, 120);
        push_bias = $urandom_range(20, 80);
        repeat (seg_len) begin
          if ($urandom_range(0, 99) < push_bias) queue_cmd(random_push());
          else queue_cmd(random_pop());
        end
      end
    end
  end

  // Reset is held at the start and never raised again once released.
  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
  end

  // Command driver. On each accepted item the heap copy is updated and the
  // expected result is queued. A new item is presented after a random idle
  // stretch; now and then a run of back-to-back items is forced so that the
  // block also sees its highest input rate.
  int send_gap = 0;
  int send_quiet = 0;

  always @(posedge clk) begin
    bmhq_pkg::res_t expected;
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!cmd_valid || cmd_ready) begin
      if (cmd_valid) begin
        predict_heap_op(cmd, expected);
        heap_replies_due.push_back(expected);
      end
      if (send_gap > 0) begin
        send_gap--;
        cmd_valid <= 1'b0;
      end else if (cmd_pending.size() > 0) begin
        cmd <= cmd_pending.pop_front();
        cmd_valid <= 1'b1;
        if (send_quiet > 0) send_quiet--;
        else if ($urandom_range(0, 39) == 0) send_quiet = $urandom_range(20, 80);
        send_gap = (send_quiet > 0) ? 0 : idle_len();
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver. Each accepted result is checked field by
  // field against the oldest expectation. Ready is dropped for random stalls,
  // with quiet stretches in which every result is taken at once.
  int take_stall = 0;
  int take_quiet = 0;

  always @(posedge clk) begin
    bmhq_pkg::res_t want;
    if (rst) begin
      res_ready <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        if (heap_replies_due.size() == 0) begin
          report_mismatch("unexpected result", 64'(res.front_prio), 64'(0));
        end else begin
          want = heap_replies_due.pop_front();
          if (res.status !== want.status)
            report_mismatch("status", 64'(res.status), 64'(want.status));
          if (res.entry_count !== want.entry_count)
            report_mismatch("entry_count", 64'(res.entry_count), 64'(want.entry_count));
          if (res.is_empty !== want.is_empty)
            report_mismatch("is_empty", 64'(res.is_empty), 64'(want.is_empty));
          if (res.front_prio !== want.front_prio)
            report_mismatch("front_prio", 64'(res.front_prio), 64'(want.front_prio));
          if (res.front_release !== want.front_release)
            report_mismatch("front_release", 64'(res.front_release),
                            64'(want.front_release));
          if (res.front_proc !== want.front_proc)
            report_mismatch("front_proc", 64'(res.front_proc), 64'(want.front_proc));
          if (res.front_delivery !== want.front_delivery)
            report_mismatch("front_delivery", 64'(res.front_delivery),
                            64'(want.front_delivery));
          if (res.front_id !== want.front_id)
            report_mismatch("front_id", 64'(res.front_id), 64'(want.front_id));
        end
      end
      if (take_stall > 0) begin
        take_stall--;
        res_ready <= 1'b0;
      end else begin
        res_ready <= 1'b1;
        if (take_quiet > 0) begin
          take_quiet--;
        end else if ($urandom_range(0, 59) == 0) begin
          take_quiet = $urandom_range(30, 120);
        end else if ($urandom_range(0, 99) < 20) begin
          take_stall = idle_len();
        end
      end
    end
  end

  // End of run: every command sent, every result returned, then a short
  // drain in case the block produces something it should not.
  initial begin
    @(negedge rst);
    @(posedge clk);
    while (cmd_pending.size() > 0 || cmd_valid) @(posedge clk);
    while (heap_replies_due.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (heap_replies_due.size() > 0)
      report_mismatch("results still owed", 64'(heap_replies_due.size()), 64'(0));
    if (mismatch_count == 0) begin
      $display("[binary_min_heap_queue_core] OK");
    end else begin
      $display("[binary_min_heap_queue_core] ERROR");
    end
    $finish;
  end

  // Watchdog. A correct run of this length with the longest idle stretches
  // on both sides takes a few milliseconds; this allows several times that.
  initial begin
    #20_000_000;
    $display("[binary_min_heap_queue_core] ERROR");
    $finish;
  end

endmodule
